/* src/lsc_pkg.sv */
// Package for the line sensor calibrate-and-locate block.
// Widths, command codes, register indexes and reset constants. No dependencies.
`timescale 1ns / 1ps
package lsc_pkg;
  localparam int unsigned DEF_NUM_SENSORS  = 16;
  localparam int unsigned DEF_BATCH_FRAMES = 10;

  localparam int unsigned CmdW   = 2;
  localparam int unsigned IdxW   = 4;
  localparam int unsigned RawW   = 12;
  localparam int unsigned ThrW   = 10;
  localparam int unsigned PosW   = 14;
  localparam int unsigned WtW    = 28;
  localparam int unsigned VtW    = 14;
  localparam int unsigned FrameW = 4;
  localparam int unsigned CfgAW  = 1;
  localparam int unsigned ScW    = 11;  // scaled value 0..1000

  localparam logic [CmdW-1:0] CMD_CAL_RESET = 2'd0;
  localparam logic [CmdW-1:0] CMD_CAL_SAMPLE = 2'd1;
  localparam logic [CmdW-1:0] CMD_POS_SAMPLE = 2'd2;

  localparam logic [CfgAW-1:0] REG_LINE_THR  = 1'd0;
  localparam logic [CfgAW-1:0] REG_NOISE_THR = 1'd1;

  localparam logic [ThrW-1:0] LINE_THR_RESET  = 10'd200;
  localparam logic [ThrW-1:0] NOISE_THR_RESET = 10'd50;
  localparam logic [RawW-1:0] CAL_LOW_RESET   = 12'd1023;
  localparam logic [ScW-1:0]  SCALE_FULL      = 11'd1000;

  // Datapath commands issued by the controller.
  typedef struct packed {
    logic load;       // capture the accepted transaction
    logic cal_clear;  // reset all calibration entries
    logic cal_update; // batch min/max update
    logic fold;       // fold one sensor (index from fold_idx)
    logic div_start;  // start divider
    logic scale_acc;  // accumulate scaled quotient
    logic pos_start;  // start position divide
    logic pos_finish; // form the result, clear frame sums
  } lsc_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic span_zero;
  } lsc_stat_t;
endpackage

/* src/lsc_div.sv */
// Shared restoring divider, one quotient bit per cycle, unsigned operands.
// Depends on lsc_pkg.
`timescale 1ns / 1ps
module lsc_div
  import lsc_pkg::*;
(
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic [WtW-1:0] num_i,
  input  logic [WtW-1:0] den_i,
  output logic           busy_o,
  output logic [WtW-1:0] quot_o
);
  localparam int unsigned CntW = $clog2(WtW + 1);

  logic [WtW-1:0]  quot_q, quot_d;
  logic [WtW-1:0]  rem_q, rem_d;
  logic [WtW-1:0]  den_q, den_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [WtW:0]    trial;

  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    trial  = {rem_q, quot_q[WtW-1]};
    if (start_i) begin
      quot_d = num_i;
      rem_d  = '0;
      den_d  = den_i;
      cnt_d  = CntW'(WtW);
    end else if (cnt_q != '0) begin
      // remainder stays below the divisor, so it fits in WtW bits
      if (trial >= {1'b0, den_q}) begin
        rem_d  = trial[WtW-1:0] - den_q;
        quot_d = {quot_q[WtW-2:0], 1'b1};
      end else begin
        rem_d  = trial[WtW-1:0];
        quot_d = {quot_q[WtW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    den_q  <= den_d;
  end

  assign busy_o = (cnt_q != '0);
  assign quot_o = quot_q;
endmodule

/* src/lsc_datapath.sv */
// Datapath: calibration tables, batch stores, scaling, accumulators, result register.
// Depends on lsc_pkg and lsc_div.
`timescale 1ns / 1ps
module lsc_datapath
  import lsc_pkg::*;
#(
  parameter int unsigned NUM_SENSORS  = DEF_NUM_SENSORS
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  lsc_cmd_t         cmd_i,
  output lsc_stat_t        stat_o,
  input  logic [IdxW-1:0]  fold_idx_i,
  input  logic [IdxW-1:0]  sensor_index_i,
  input  logic [RawW-1:0]  sample_value_i,
  input  logic             batch_first_i,
  input  logic             cfg_we_i,
  input  logic [CfgAW-1:0] cfg_addr_i,
  input  logic [ThrW-1:0]  cfg_wdata_i,
  output logic [PosW-1:0]  line_position_o,
  output logic             line_seen_o
);
  localparam int unsigned SelW = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1;
  localparam int unsigned MaxPos = (NUM_SENSORS - 1) * 1000;
  localparam int unsigned CtrPos = (NUM_SENSORS - 1) * 500;

  logic [RawW-1:0] cal_low_q  [NUM_SENSORS];
  logic [RawW-1:0] cal_high_q [NUM_SENSORS];
  logic [RawW-1:0] batch_low_q  [NUM_SENSORS];
  logic [RawW-1:0] batch_high_q [NUM_SENSORS];

  logic [ThrW-1:0] line_thr_q, noise_thr_q;
  logic [IdxW-1:0] idx_q;
  logic [RawW-1:0] raw_q;
  logic            idx_ok;
  logic [SelW-1:0] sel, fsel;

  logic [WtW-1:0]  wt_q;
  logic [VtW-1:0]  vt_q;
  logic            seen_q;
  logic [PosW-1:0] last_pos_q;
  logic [PosW-1:0] pos_q;
  logic            pos_seen_q;

  // scaling operands
  logic signed [RawW:0] span_s, diff_s;
  logic                 neg_q;
  logic                 span_zero;
  logic [WtW-1:0]       num, den;
  logic                 div_busy;
  logic [WtW-1:0]       quot;
  logic [ScW-1:0]       v;
  logic [WtW-1:0]       w, wt_sum;
  logic [VtW:0]         vt_sum;
  logic                 use_pos_div;

  assign idx_ok = ({28'd0, idx_q} < 32'(NUM_SENSORS));
  assign sel    = idx_q[SelW-1:0];
  assign fsel   = fold_idx_i[SelW-1:0];

  assign span_s    = $signed({1'b0, cal_high_q[sel]}) - $signed({1'b0, cal_low_q[sel]});
  assign diff_s    = $signed({1'b0, raw_q}) - $signed({1'b0, cal_low_q[sel]});
  assign span_zero = (span_s == '0);

  // magnitude divide; a negative result is forced to zero afterward (truncation toward zero)
  logic [RawW:0] span_mag, diff_mag;
  assign span_mag = span_s[RawW] ? RawW'(0) - span_s : span_s;
  assign diff_mag = diff_s[RawW] ? RawW'(0) - diff_s : diff_s;

  always_comb begin
    if (use_pos_div) begin
      num = wt_q;
      den = WtW'(vt_q);
    end else begin
      num = WtW'(diff_mag) * WtW'(1000);
      den = WtW'(span_mag);
    end
  end
  assign use_pos_div = cmd_i.pos_start;

  lsc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cmd_i.div_start | cmd_i.pos_start),
    .num_i  (num),
    .den_i  (den),
    .busy_o (div_busy),
    .quot_o (quot)
  );

  always_comb begin
    if (span_zero || neg_q) v = '0;
    else if (quot > WtW'(SCALE_FULL)) v = SCALE_FULL;
    else v = quot[ScW-1:0];
  end
  assign w      = WtW'(v) * WtW'(idx_q) * WtW'(1000);
  assign wt_sum = wt_q + w;
  assign vt_sum = {1'b0, vt_q} + (VtW + 1)'(v);

  assign stat_o.div_busy  = div_busy;
  assign stat_o.span_zero = span_zero;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_thr_q  <= LINE_THR_RESET;
      noise_thr_q <= NOISE_THR_RESET;
      wt_q        <= '0;
      vt_q        <= '0;
      seen_q      <= 1'b0;
      last_pos_q  <= '0;
      for (int k = 0; k < NUM_SENSORS; k++) begin
        cal_low_q[k]  <= CAL_LOW_RESET;
        cal_high_q[k] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_addr_i)
          REG_LINE_THR:  line_thr_q  <= cfg_wdata_i;
          REG_NOISE_THR: noise_thr_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (cmd_i.cal_clear) begin
        for (int k = 0; k < NUM_SENSORS; k++) begin
          cal_low_q[k]  <= CAL_LOW_RESET;
          cal_high_q[k] <= '0;
        end
      end
      if (cmd_i.fold) begin
        if (batch_low_q[fsel] > cal_high_q[fsel]) cal_high_q[fsel] <= batch_low_q[fsel];
        if (batch_high_q[fsel] < cal_low_q[fsel]) cal_low_q[fsel] <= batch_high_q[fsel];
      end
      if (cmd_i.scale_acc && idx_ok) begin
        if (v > ScW'(line_thr_q)) seen_q <= 1'b1;
        if (v > ScW'(noise_thr_q)) begin
          wt_q <= (wt_sum < wt_q) ? {WtW{1'b1}} : wt_sum;
          vt_q <= vt_sum[VtW] ? {VtW{1'b1}} : vt_sum[VtW-1:0];
        end
      end
      if (cmd_i.pos_finish) begin
        if (seen_q && vt_q != '0) begin
          last_pos_q <= (quot > WtW'(MaxPos)) ? PosW'(MaxPos) : quot[PosW-1:0];
        end
        wt_q   <= '0;
        vt_q   <= '0;
        seen_q <= 1'b0;
      end
    end
  end

  logic [PosW-1:0] qpos, upos;
  assign qpos = (quot > WtW'(MaxPos)) ? PosW'(MaxPos) : quot[PosW-1:0];
  always_comb begin
    if (!seen_q) upos = (last_pos_q < PosW'(CtrPos)) ? '0 : PosW'(MaxPos);
    else if (vt_q != '0) upos = qpos;
    else upos = last_pos_q;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      idx_q <= sensor_index_i;
      raw_q <= sample_value_i;
    end
    if (cmd_i.div_start) neg_q <= diff_s[RawW] ^ span_s[RawW];
    if (cmd_i.cal_update && idx_ok) begin
      if (batch_first_i || raw_q < batch_low_q[sel]) batch_low_q[sel] <= raw_q;
      if (batch_first_i || raw_q > batch_high_q[sel]) batch_high_q[sel] <= raw_q;
    end
    if (cmd_i.pos_finish) begin
      pos_q      <= upos - PosW'(CtrPos);
      pos_seen_q <= seen_q;
    end
  end

  assign line_position_o = pos_q;
  assign line_seen_o     = pos_seen_q;
endmodule

/* src/lsc_ctrl.sv */
// Controller state machine: sequences transactions through the datapath.
// Depends on lsc_pkg.
`timescale 1ns / 1ps
module lsc_ctrl
  import lsc_pkg::*;
#(
  parameter int unsigned NUM_SENSORS  = DEF_NUM_SENSORS,
  parameter int unsigned BATCH_FRAMES = DEF_BATCH_FRAMES
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic [CmdW-1:0] cmd_i,
  input  logic            last_in_frame_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output lsc_cmd_t        dp_cmd_o,
  input  lsc_stat_t       dp_stat_i,
  output logic [IdxW-1:0] fold_idx_o,
  output logic            batch_first_o
);
  typedef enum logic [2:0] {
    S_IDLE, S_CAL, S_FOLD, S_SCALE, S_SWAIT, S_PWAIT, S_PFIN
  } state_e;

  state_e          state_q;
  logic            last_q;
  logic [FrameW-1:0] frame_q;
  logic [IdxW-1:0] fidx_q;
  logic            out_valid_q;
  logic            accept;

  // accept only while idle and any prior result has been taken
  assign in_stall_o  = (state_q != S_IDLE) || (out_valid_q && out_stall_i);
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign fold_idx_o  = fidx_q;
  assign batch_first_o = (frame_q == '0);

  always_comb begin
    dp_cmd_o = '0;
    dp_cmd_o.load = accept;
    unique case (state_q)
      S_CAL:   dp_cmd_o.cal_update = 1'b1;
      S_FOLD:  dp_cmd_o.fold = 1'b1;
      S_SCALE: dp_cmd_o.div_start = 1'b1;
      S_SWAIT: dp_cmd_o.scale_acc = !dp_stat_i.div_busy;
      S_PWAIT: dp_cmd_o.pos_finish = !dp_stat_i.div_busy;
      S_PFIN:  dp_cmd_o.pos_start = 1'b1;
      default: dp_cmd_o.cal_clear = accept && cmd_i == CMD_CAL_RESET;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      last_q      <= 1'b0;
      frame_q     <= '0;
      fidx_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            last_q <= last_in_frame_i;
            if (cmd_i == CMD_CAL_SAMPLE) state_q <= S_CAL;
            else if (cmd_i == CMD_POS_SAMPLE) state_q <= S_SCALE;
          end
        end
        S_CAL: begin
          state_q <= S_IDLE;
          if (last_q) begin
            if (frame_q + 1'b1 >= FrameW'(BATCH_FRAMES)) begin
              frame_q <= '0;
              fidx_q  <= '0;
              state_q <= S_FOLD;
            end else begin
              frame_q <= frame_q + 1'b1;
            end
          end
        end
        S_FOLD: begin
          fidx_q <= fidx_q + 1'b1;
          if (fidx_q == IdxW'(NUM_SENSORS - 1)) state_q <= S_IDLE;
        end
        S_SCALE: state_q <= S_SWAIT;
        S_SWAIT: begin
          if (!dp_stat_i.div_busy) state_q <= last_q ? S_PFIN : S_IDLE;
        end
        S_PFIN: state_q <= S_PWAIT;
        S_PWAIT: begin
          if (!dp_stat_i.div_busy) begin
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule

/* src/line_sensor_calibrate_and_locate_top.sv */
// Top level of the line sensor calibrate-and-locate block.
// Depends on lsc_pkg, lsc_ctrl, lsc_datapath, lsc_div.
//
// Input channel: in_valid_i/in_stall_o with cmd, sensor_index, sample_value
// and last_in_frame. One transaction per sample.
// Output channel: out_valid_o/out_stall_i with line_position (signed,
// centered) and line_seen; one transaction at the end of each position frame.
// Configuration: cfg_we_i writes cfg_wdata_i to register cfg_addr_i
// (0 line threshold, 1 noise threshold); write only while idle.
// Sequencing: the last calibration sample of a batch is followed by a fold that
// visits each of the NUM_SENSORS sensors in turn. A position sample runs the
// bit-serial 28-bit divider that forms the scaled value; a frame's last sample
// then runs the position divide through the same divider, and the result
// appears once that divide is done.
// Reset clears calibration to its default and thresholds to 200 and 50.
// A result held under out_stall_i blocks only the next transaction accepted
// after it; the block stays stalled until the result is taken.
`timescale 1ns / 1ps
module line_sensor_calibrate_and_locate_top
  import lsc_pkg::*;
#(
  parameter int unsigned NUM_SENSORS  = DEF_NUM_SENSORS,
  parameter int unsigned BATCH_FRAMES = DEF_BATCH_FRAMES
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [CmdW-1:0]  cmd_i,
  input  logic [IdxW-1:0]  sensor_index_i,
  input  logic [RawW-1:0]  sample_value_i,
  input  logic             last_in_frame_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic signed [PosW-1:0] line_position_o,
  output logic             line_seen_o,
  input  logic             cfg_we_i,
  input  logic [CfgAW-1:0] cfg_addr_i,
  input  logic [ThrW-1:0]  cfg_wdata_i
);
  lsc_cmd_t        dp_cmd;
  lsc_stat_t       dp_stat;
  logic [IdxW-1:0] fold_idx;
  logic            batch_first;
  logic [PosW-1:0] pos;

  lsc_ctrl #(.NUM_SENSORS(NUM_SENSORS), .BATCH_FRAMES(BATCH_FRAMES)) u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .cmd_i, .last_in_frame_i,
    .out_valid_o, .out_stall_i,
    .dp_cmd_o(dp_cmd), .dp_stat_i(dp_stat),
    .fold_idx_o(fold_idx), .batch_first_o(batch_first)
  );

  lsc_datapath #(.NUM_SENSORS(NUM_SENSORS)) u_dp (
    .clk_i, .rst_ni,
    .cmd_i(dp_cmd), .stat_o(dp_stat),
    .fold_idx_i(fold_idx), .sensor_index_i, .sample_value_i,
    .batch_first_i(batch_first),
    .cfg_we_i, .cfg_addr_i, .cfg_wdata_i,
    .line_position_o(pos), .line_seen_o
  );

  assign line_position_o = $signed(pos);
endmodule

/* src/lsc_checker.sv */
// Port-level checker for the line sensor top level, bound in below.
// Depends on lsc_pkg.
`timescale 1ns / 1ps
module lsc_checker
  import lsc_pkg::*;
(
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_valid_i,
  input logic            in_stall_o,
  input logic [CmdW-1:0] cmd_i,
  input logic            out_valid_o,
  input logic            out_stall_i,
  input logic [PosW-1:0] line_position_o
);
  // a non-position transaction never yields a result next cycle
  a_no_out_after_cal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && cmd_i != CMD_POS_SAMPLE && !out_valid_o) |=> !out_valid_o)
    else $error("result after non-position transaction");

  // busy after accepting a position sample
  a_busy_after_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && cmd_i == CMD_POS_SAMPLE) |=> in_stall_o)
    else $error("accepted during position work");

  // a stalled result keeps its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(line_position_o)))
    else $error("stalled result changed");
endmodule

bind line_sensor_calibrate_and_locate_top lsc_checker u_chk (
  .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .cmd_i, .out_valid_o, .out_stall_i,
  .line_position_o
);

/* test/lsc_frame_checker.sv */
// Checker for the line sensor calibrate-and-locate block: watches the sample,
// result and register ports, predicts frame results, compares. Uses lsc_pkg.
`timescale 1ns / 1ps
module lsc_frame_checker
  import lsc_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  input  logic                   in_stall_i,
  input  logic [CmdW-1:0]        cmd_i,
  input  logic [IdxW-1:0]        sensor_index_i,
  input  logic [RawW-1:0]        sample_value_i,
  input  logic                   last_in_frame_i,
  input  logic                   out_valid_i,
  input  logic                   out_stall_i,
  input  logic signed [PosW-1:0] line_position_i,
  input  logic                   line_seen_i,
  input  logic                   cfg_we_i,
  input  logic [CfgAW-1:0]       cfg_addr_i,
  input  logic [ThrW-1:0]        cfg_wdata_i,
  output int                     fail_count_o,
  output int                     pending_o,
  output int                     results_o,
  output int                     seen_frames_o,
  output int                     folds_o
);
  localparam int NSENS     = DEF_NUM_SENSORS;
  localparam int NBATCH    = DEF_BATCH_FRAMES;
  localparam int CENTER    = (NSENS - 1) * 500;
  localparam int MAX_PLACE = (NSENS - 1) * 1000;
  localparam int WSUM_MAX  = (1 << WtW) - 1;
  localparam int VSUM_MAX  = (1 << VtW) - 1;

  typedef struct {
    logic signed [PosW-1:0] pos;
    logic                   seen;
  } frame_fix_t;

  frame_fix_t        fix_q[$];
  logic [RawW-1:0]   cal_lo [NSENS];
  logic [RawW-1:0]   cal_hi [NSENS];
  logic [RawW-1:0]   bat_lo [NSENS];
  logic [RawW-1:0]   bat_hi [NSENS];
  logic [FrameW-1:0] bat_frames;
  logic [WtW-1:0]    wsum;
  logic [VtW-1:0]    vsum;
  logic              seen;
  logic [PosW-1:0]   last_place;
  logic [ThrW-1:0]   line_thr, noise_thr;

  function automatic int scaled(int idx, int raw);
    int span, x;
    span = int'(cal_hi[idx]) - int'(cal_lo[idx]);
    x = 0;
    if (span != 0) x = ((raw - int'(cal_lo[idx])) * 1000) / span;
    if (x < 0) x = 0;
    else if (x > 1000) x = 1000;
    return x;
  endfunction

  task automatic apply_sample(logic [CmdW-1:0] cmd, int idx, int raw, logic last);
    int v, q, place;
    frame_fix_t f;
    if (cmd == CMD_CAL_RESET) begin
      for (int k = 0; k < NSENS; k++) begin
        cal_lo[k] = CAL_LOW_RESET;
        cal_hi[k] = '0;
      end
    end else if (cmd == CMD_CAL_SAMPLE) begin
      if (idx < NSENS) begin
        if (bat_frames == 0 || raw < bat_lo[idx]) bat_lo[idx] = RawW'(raw);
        if (bat_frames == 0 || raw > bat_hi[idx]) bat_hi[idx] = RawW'(raw);
      end
      if (last) begin
        bat_frames = bat_frames + 1'b1;
        if (bat_frames >= NBATCH) begin
          // fold: cal_hi rises to the batch low, cal_lo falls to the batch high
          for (int k = 0; k < NSENS; k++) begin
            if (bat_lo[k] > cal_hi[k]) cal_hi[k] = bat_lo[k];
            if (bat_hi[k] < cal_lo[k]) cal_lo[k] = bat_hi[k];
          end
          bat_frames = '0;
          folds_o++;
        end
      end
    end else if (cmd == CMD_POS_SAMPLE) begin
      if (idx < NSENS) begin
        v = scaled(idx, raw);
        if (v > line_thr) seen = 1'b1;
        if (v > noise_thr) begin
          wsum = (int'(wsum) + v * idx * 1000 > WSUM_MAX) ? WtW'(WSUM_MAX) :
                 WtW'(int'(wsum) + v * idx * 1000);
          vsum = (int'(vsum) + v > VSUM_MAX) ? VtW'(VSUM_MAX) : VtW'(int'(vsum) + v);
        end
      end
      if (last) begin
        if (!seen) begin
          place = (last_place < CENTER) ? 0 : MAX_PLACE;
        end else begin
          if (vsum != 0) begin
            q = int'(wsum) / int'(vsum);
            if (q > MAX_PLACE) q = MAX_PLACE;
            last_place = PosW'(q);
          end
          place = last_place;
        end
        f.pos  = PosW'(place - CENTER);
        f.seen = seen;
        fix_q.push_back(f);
        wsum = '0;
        vsum = '0;
        seen = 1'b0;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    frame_fix_t f;
    if (!rst_ni) begin
      for (int k = 0; k < NSENS; k++) begin
        cal_lo[k] = CAL_LOW_RESET;
        cal_hi[k] = '0;
        bat_lo[k] = '0;
        bat_hi[k] = '0;
      end
      bat_frames = '0;
      wsum = '0;
      vsum = '0;
      seen = 1'b0;
      last_place = '0;
      line_thr = LINE_THR_RESET;
      noise_thr = NOISE_THR_RESET;
      fix_q.delete();
      fail_count_o = 0;
      results_o = 0;
      seen_frames_o = 0;
      folds_o = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_addr_i == REG_LINE_THR) line_thr = cfg_wdata_i;
        else if (cfg_addr_i == REG_NOISE_THR) noise_thr = cfg_wdata_i;
      end
      if (in_valid_i && !in_stall_i)
        apply_sample(cmd_i, sensor_index_i, sample_value_i, last_in_frame_i);
      if (out_valid_i && !out_stall_i) begin
        results_o++;
        if (line_seen_i) seen_frames_o++;
        if (fix_q.size() == 0) begin
          $display("%0t: unexpected result pos=%0d seen=%0b", $time, line_position_i,
                   line_seen_i);
          fail_count_o++;
        end else begin
          f = fix_q.pop_front();
          if (line_position_i !== f.pos) begin
            $display("%0t: line_position expected %0d actual %0d", $time, f.pos,
                     line_position_i);
            fail_count_o++;
          end
          if (line_seen_i !== f.seen) begin
            $display("%0t: line_seen expected %0b actual %0b", $time, f.seen, line_seen_i);
            fail_count_o++;
          end
        end
      end
    end
  end

  assign pending_o = fix_q.size();
endmodule

/* test/tb.sv */
// Testbench top for line_sensor_calibrate_and_locate_top: drives samples,
// register writes and output stalls. Depends on lsc_pkg and lsc_frame_checker.
`timescale 1ns / 1ps
module tb;
  import lsc_pkg::*;

  localparam logic [CmdW-1:0] CMD_UNUSED = 2'd3;
  localparam int NSENS      = DEF_NUM_SENSORS;
  localparam int IDLE_LIMIT = 3000;
  localparam int SETTLE     = 100;
  localparam int PHASE_ITEMS = 300;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [CmdW-1:0]        cmd = '0;
  logic [IdxW-1:0]        sensor_index = '0;
  logic [RawW-1:0]        sample_value = '0;
  logic                   last_in_frame = 1'b0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic signed [PosW-1:0] line_position;
  logic                   line_seen;
  logic                   cfg_we = 1'b0;
  logic [CfgAW-1:0]       cfg_addr = '0;
  logic [ThrW-1:0]        cfg_wdata = '0;

  int fails, pending, results, seen_frames, folds;
  int sent = 0;
  int burst_left = 0;
  int idle_cycles = 0;
  int base [NSENS];
  int spread [NSENS];

  always #5 clk = ~clk;

  line_sensor_calibrate_and_locate_top u_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .cmd_i(cmd), .sensor_index_i(sensor_index), .sample_value_i(sample_value),
    .last_in_frame_i(last_in_frame),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .line_position_o(line_position), .line_seen_o(line_seen),
    .cfg_we_i(cfg_we), .cfg_addr_i(cfg_addr), .cfg_wdata_i(cfg_wdata)
  );

  lsc_frame_checker u_chk (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_i(in_stall),
    .cmd_i(cmd), .sensor_index_i(sensor_index), .sample_value_i(sample_value),
    .last_in_frame_i(last_in_frame),
    .out_valid_i(out_valid), .out_stall_i(out_stall),
    .line_position_i(line_position), .line_seen_i(line_seen),
    .cfg_we_i(cfg_we), .cfg_addr_i(cfg_addr), .cfg_wdata_i(cfg_wdata),
    .fail_count_o(fails), .pending_o(pending), .results_o(results),
    .seen_frames_o(seen_frames), .folds_o(folds)
  );

  // receiver stall pattern: stall_mode is redrawn at random as stall_tick advances
  int stall_tick = 0;
  int stall_mode = 0;
  always @(posedge clk) begin
    stall_tick <= stall_tick + 1;
    if (stall_tick % 128 == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 1) == 0);
      2: out_stall <= ((stall_tick / 16) % 2 == 1);
      default: out_stall <= ($urandom_range(0, 7) == 0);
    endcase
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("line_sensor_calibrate_and_locate_top verification failed");
        $finish;
      end
    end
  end

  // one transaction; returns at the edge that accepted it
  task automatic send(logic [CmdW-1:0] c, int idx, int raw, logic last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid      <= 1'b1;
    cmd           <= c;
    sensor_index  <= IdxW'(idx);
    sample_value  <= RawW'(raw);
    last_in_frame <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [CfgAW-1:0] addr, int val);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= ThrW'(val);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_thresholds(int line_v, int noise_v);
    drain();
    write_reg(REG_LINE_THR, line_v);
    write_reg(REG_NOISE_THR, noise_v);
  endtask

  // one calibration batch over every sensor, per-sensor base plus jitter
  task automatic cal_batch();
    for (int k = 0; k < NSENS; k++) begin
      case ($urandom_range(0, 7))
        0: base[k] = 1023;
        1: base[k] = $urandom_range(0, 1000);
        default: base[k] = $urandom_range(1100, 3200);
      endcase
      spread[k] = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 300);
    end
    for (int fr = 0; fr < DEF_BATCH_FRAMES; fr++)
      for (int k = 0; k < NSENS; k++)
        send(CMD_CAL_SAMPLE, k, base[k] + $urandom_range(0, spread[k]), k == NSENS - 1);
  endtask

  // position frame with a bright spot around a random center
  task automatic pos_frame();
    int center, len, idx, raw;
    center = $urandom_range(0, NSENS - 1);
    case ($urandom_range(0, 7))
      0: len = $urandom_range(1, NSENS);
      1: len = $urandom_range(NSENS + 1, 40);
      default: len = NSENS;
    endcase
    for (int i = 0; i < len; i++) begin
      idx = (len == NSENS) ? i : $urandom_range(0, NSENS - 1);
      if (idx >= center - 1 && idx <= center + 1 && center != 99)
        raw = $urandom_range(2500, 4095);
      else if ($urandom_range(0, 3) == 0)
        raw = $urandom_range(0, 4095);
      else
        raw = $urandom_range(0, 1500);
      send(CMD_POS_SAMPLE, idx, raw, i == len - 1);
    end
  endtask

  task automatic noise_item();
    case ($urandom_range(0, 9))
      0: send(CMD_CAL_RESET, $urandom_range(0, 15), $urandom_range(0, 4095),
              1'($urandom_range(0, 1)));
      1, 2: send(CMD_UNUSED, $urandom_range(0, 15), $urandom_range(0, 4095),
                 1'($urandom_range(0, 1)));
      3, 4, 5: send(CMD_CAL_SAMPLE, $urandom_range(0, 15), $urandom_range(0, 4095),
                    $urandom_range(0, 3) == 0);
      default: send(CMD_POS_SAMPLE, $urandom_range(0, 15), $urandom_range(0, 4095),
                    1'($urandom_range(0, 1)));
    endcase
  endtask

  task automatic run_phase(int line_v, int noise_v, bit recal);
    int target;
    set_thresholds(line_v, noise_v);
    target = sent + PHASE_ITEMS;
    if (recal) begin
      if ($urandom_range(0, 1) == 0) send(CMD_CAL_RESET, 0, 0, 1'b0);
      cal_batch();
    end
    // saturating frame: many bright samples on the outermost sensor
    for (int i = 0; i < 24; i++)
      send(CMD_POS_SAMPLE, NSENS - 1, 4095, i == 23);
    while (sent < target) begin
      if ($urandom_range(0, 9) == 0) noise_item();
      else pos_frame();
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: commands, field extremes, line lost on both sides
    send(CMD_UNUSED, 15, 4095, 1'b1);
    send(CMD_CAL_RESET, 0, 0, 1'b0);
    send(CMD_POS_SAMPLE, 0, 0, 1'b0);
    send(CMD_POS_SAMPLE, 15, 4095, 1'b1);
    send(CMD_POS_SAMPLE, 7, 2048, 1'b1);
    // first frame of the first batch must touch every sensor
    send(CMD_CAL_SAMPLE, 0, 4095, 1'b0);
    cal_batch();
    send(CMD_POS_SAMPLE, 15, 4095, 1'b1);
    send(CMD_POS_SAMPLE, 0, 0, 1'b1);
    send(CMD_POS_SAMPLE, 0, 4095, 1'b1);
    send(CMD_POS_SAMPLE, 3, 0, 1'b1);
    set_thresholds(1000, 1000);
    send(CMD_POS_SAMPLE, 15, 4095, 1'b1);
    set_thresholds(0, 0);
    send(CMD_POS_SAMPLE, 8, 4095, 1'b0);
    send(CMD_POS_SAMPLE, 8, 0, 1'b1);
    // seen but nothing summed
    set_thresholds(10, 900);
    send(CMD_POS_SAMPLE, 4, 1500, 1'b1);

    run_phase(LINE_THR_RESET, NOISE_THR_RESET, 1'b1);
    run_phase(0, 0, 1'b0);
    run_phase(1000, 1000, 1'b1);
    run_phase(100, 500, 1'b0);
    run_phase($urandom_range(0, 1023), $urandom_range(0, 1023), 1'b1);
    run_phase(512, 341, 1'b0);

    drain();
    $display("covered %0d samples, %0d frame results (%0d with line seen), %0d folds",
             sent, results, seen_frames, folds);
    if (fails == 0 && pending == 0) begin
      $display("line_sensor_calibrate_and_locate_top verification clean");
    end else begin
      $display("line_sensor_calibrate_and_locate_top verification failed");
    end
    $finish;
  end
endmodule

/* sim.f */
src/lsc_pkg.sv
src/lsc_div.sv
src/lsc_datapath.sv
src/lsc_ctrl.sv
src/line_sensor_calibrate_and_locate_top.sv
src/lsc_checker.sv
test/lsc_frame_checker.sv
test/tb.sv
